// ===== rtl/u2a_pkg.sv =====
// Package for the UTF-8 to ASCII fallback block: payload structs, job record,
// sequence codes, byte constants and the lead-byte length function.
// No dependencies.
`timescale 1ns / 1ps

package u2a_pkg;

  localparam int unsigned CNT_W   = 12;
  localparam int unsigned CAP_W   = 13;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(1 << CNT_W);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  localparam logic REG_PASSTHROUGH  = 1'b0;
  localparam logic REG_OUT_CAPACITY = 1'b1;

  localparam logic [7:0] B_LEAD_E2 = 8'hE2;
  localparam logic [7:0] B_LEAD_C2 = 8'hC2;
  localparam logic [7:0] B_LEAD_C3 = 8'hC3;
  localparam logic [7:0] B_SEC_89  = 8'h89;
  localparam logic [7:0] B_SEC_80  = 8'h80;
  localparam logic [7:0] B_APPROX  = 8'h88;
  localparam logic [7:0] B_EN_DASH = 8'h93;
  localparam logic [7:0] B_EM_DASH = 8'h94;
  localparam logic [7:0] B_ELLIPS  = 8'hA6;
  localparam logic [7:0] B_DEGREE  = 8'hB0;
  localparam logic [7:0] B_MICRO   = 8'hB5;
  localparam logic [7:0] B_TIMES   = 8'h97;
  localparam logic [7:0] B_ASCII_END = 8'h80;

  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef enum logic [1:0] {
    SEQ_NONE,
    SEQ_LEAD,
    SEQ_SECOND
  } seq_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_end;
  } out_item_t;

  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [2:0]      nchar;
    logic            term;
  } job_t;

  function automatic logic [1:0] extra_bytes(input logic [7:0] c);
    logic [1:0] r;
    r = 2'd0;
    if (c[7:5] == 3'b110) r = 2'd1;
    else if (c[7:4] == 4'b1110) r = 2'd2;
    else if (c[7:3] == 5'b11110) r = 2'd3;
    return r;
  endfunction

endpackage

// ===== rtl/u2a_front.sv =====
// Front part: accepts input bytes, tracks pending sequences and the character
// count, and pushes a job record for each byte that yields output. Uses u2a_pkg.
`timescale 1ns / 1ps

module u2a_front import u2a_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             passthrough_i,
  input  logic [CAP_W-1:0] cap_i,
  input  logic             in_valid_i,
  input  in_item_t         in_data_i,
  output logic             in_stall_o,
  input  logic             full_i,
  output logic             push_o,
  output job_t             job_o
);

  logic [7:0]       lead_q, lead_d;
  logic [7:0]       second_q, second_d;
  seq_e             seq_q, seq_d;
  logic [1:0]       skip_q, skip_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic [CAP_W-1:0] limit;
  logic [CAP_W-1:0] used;
  logic [CAP_W-1:0] room;
  logic [3:0][7:0]  cand;
  logic [2:0]       cand_len;
  logic             all_or_none;
  logic [2:0]       n;
  logic [7:0]       b;
  logic             accept;

  always_comb begin
    b        = in_data_i.in_byte;
    limit    = (cap_i > CAP_MAX) ? CAP_MAX : cap_i;
    used     = {1'b0, count_q} + CAP_W'(1);
    room     = (limit > used) ? (limit - used) : '0;
    lead_d   = lead_q;
    second_d = second_q;
    seq_d    = seq_q;
    skip_d   = skip_q;
    cand     = '0;
    cand_len = 3'd0;
    all_or_none = 1'b0;

    if (passthrough_i) begin
      cand[0]  = b;
      cand_len = 3'd1;
      seq_d    = SEQ_NONE;
      skip_d   = 2'd0;
    end else if (skip_q != 2'd0) begin
      skip_d = skip_q - 2'd1;
    end else begin
      case (seq_q)
        SEQ_NONE: begin
          if (b < B_ASCII_END) begin
            cand[0]  = b;
            cand_len = 3'd1;
          end else if (b inside {B_LEAD_E2, B_LEAD_C2, B_LEAD_C3}) begin
            lead_d = b;
            seq_d  = SEQ_LEAD;
          end else begin
            cand[0]  = CH_QUEST;
            cand_len = 3'd1;
            skip_d   = extra_bytes(b);
          end
        end
        SEQ_LEAD: begin
          seq_d    = SEQ_NONE;
          cand_len = 3'd1;
          if (lead_q == B_LEAD_C2) begin
            if (b == B_DEGREE) begin
              cand     = {CH_G, CH_E, CH_D, CH_SPACE};
              cand_len = 3'd4;
            end else if (b == B_MICRO) begin
              cand[0] = CH_U;
            end else begin
              cand[0] = CH_QUEST;
            end
          end else if (lead_q == B_LEAD_C3) begin
            cand[0] = (b == B_TIMES) ? CH_X : CH_QUEST;
          end else if (b == B_SEC_89 || b == B_SEC_80) begin
            cand_len = 3'd0;
            second_d = b;
            seq_d    = SEQ_SECOND;
          end else begin
            cand[0] = CH_QUEST;
            skip_d  = 2'd1;
          end
        end
        SEQ_SECOND: begin
          seq_d    = SEQ_NONE;
          cand_len = 3'd1;
          if (second_q == B_SEC_89 && b == B_APPROX) begin
            cand[0] = CH_TILDE;
          end else if (second_q == B_SEC_80 && (b == B_EN_DASH || b == B_EM_DASH)) begin
            cand[0] = CH_DASH;
          end else if (second_q == B_SEC_80 && b == B_ELLIPS) begin
            cand        = {8'h00, CH_DOT, CH_DOT, CH_DOT};
            cand_len    = 3'd3;
            all_or_none = 1'b1;
          end else begin
            cand[0] = CH_QUEST;
          end
        end
        default: begin
          seq_d = SEQ_NONE;
        end
      endcase
    end

    // A string that ends inside a sequence closes it with a question mark.
    if (in_data_i.in_last && seq_d != SEQ_NONE) begin
      cand[0]     = CH_QUEST;
      cand_len    = 3'd1;
      all_or_none = 1'b0;
    end

    if (all_or_none) begin
      n = (room >= CAP_W'(3)) ? 3'd3 : 3'd0;
    end else begin
      n = (room < CAP_W'(cand_len)) ? room[2:0] : cand_len;
    end

    accept  = in_valid_i && !full_i;
    count_d = count_q + CNT_W'(n);
    if (in_data_i.in_last) begin
      lead_d   = '0;
      second_d = '0;
      seq_d    = SEQ_NONE;
      skip_d   = 2'd0;
      count_d  = '0;
    end
  end

  assign in_stall_o  = full_i;
  assign push_o      = accept && (n != 3'd0 || in_data_i.in_last);
  assign job_o.chars = cand;
  assign job_o.nchar = n;
  assign job_o.term  = in_data_i.in_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q   <= '0;
      second_q <= '0;
      seq_q    <= SEQ_NONE;
      skip_q   <= 2'd0;
      count_q  <= '0;
    end else if (accept) begin
      lead_q   <= lead_d;
      second_q <= second_d;
      seq_q    <= seq_d;
      skip_q   <= skip_d;
      count_q  <= count_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.in_last |=> count_q == '0 && seq_q == SEQ_NONE)
    else $error("count not cleared after string end");
  a_no_skip_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(skip_q != 2'd0 && seq_q != SEQ_NONE))
    else $error("skip and pending sequence at once");
`endif

endmodule

// ===== rtl/u2a_fifo.sv =====
// Short job queue between the front and back parts.
// Uses u2a_pkg for the job record and queue depth.
`timescale 1ns / 1ps

module u2a_fifo import u2a_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output job_t head_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q;
  logic [QPTR_W-1:0] rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push;
  logic              do_pop;

  assign full_o       = (cnt_q == QCNT_W'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + QPTR_W'(1);
      if (do_pop)  rd_q <= rd_q + QPTR_W'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("job pushed into a full queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== rtl/u2a_back.sv =====
// Back part: walks the job at the queue head and sends one result per cycle,
// while the output is not stalled, through an output register. Uses u2a_pkg.
`timescale 1ns / 1ps

module u2a_back import u2a_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  job_t      head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic [2:0] idx_q;
  logic       out_valid_q;
  out_item_t  out_q;
  out_item_t  item;
  logic       load;
  logic       fire;
  logic       done;

  always_comb begin
    if (idx_q < head_i.nchar) begin
      item.out_char = head_i.chars[idx_q[1:0]];
      item.out_end  = 1'b0;
      done          = (idx_q + 3'd1 == head_i.nchar) && !head_i.term;
    end else begin
      item.out_char = 8'h00;
      item.out_end  = 1'b1;
      done          = 1'b1;
    end
    load = !out_valid_q || !out_stall_i;
    fire = head_valid_i && load;
  end

  assign pop_o       = fire && done;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 3'd0;
    end else begin
      if (load) out_valid_q <= fire;
      if (fire) idx_q <= done ? 3'd0 : idx_q + 3'd1;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q <= head_i.nchar)
    else $error("job index past the job length");
`endif

endmodule

// ===== rtl/utf8_to_ascii_fallback.sv =====
// Top level of the UTF-8 to ASCII fallback block: configuration registers and
// the front, queue and back parts. Uses u2a_pkg, u2a_front, u2a_fifo, u2a_back.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o   in_item_t  (in_byte, in_last)
//   out      output     out_valid_o / out_stall_i out_item_t (out_char, out_end)
//   config   input      APB write/read            passthrough, out_capacity
//
// One input byte is taken per cycle while the two-entry job queue has room.
// The back part sends one result per cycle while the output is not stalled; a
// byte yields zero to five results (up to four characters and an end marker).
// Reset is asynchronous and active low and clears no memory.
// A stall on the output fills the queue and then stalls the input.
`timescale 1ns / 1ps

module utf8_to_ascii_fallback import u2a_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic             pass_q;
  logic [CAP_W-1:0] cap_q;
  logic             push;
  job_t             job;
  logic             full;
  logic             pop;
  logic             head_valid;
  job_t             head;

  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_PASSTHROUGH:  prdata = {31'b0, pass_q};
      REG_OUT_CAPACITY: prdata = {{(32 - CAP_W){1'b0}}, cap_q};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= 1'b0;
      cap_q  <= CAP_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_PASSTHROUGH:  pass_q <= pwdata[0];
        REG_OUT_CAPACITY: cap_q  <= pwdata[CAP_W-1:0];
        default:          ;
      endcase
    end
  end

  u2a_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .passthrough_i (pass_q),
    .cap_i         (cap_q),
    .in_valid_i    (in_valid_i),
    .in_data_i     (in_data_i),
    .in_stall_o    (in_stall_o),
    .full_i        (full),
    .push_o        (push),
    .job_o         (job)
  );

  u2a_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (job),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  u2a_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
